// ----- rtl/spnor_pkg.sv -----
// Shared types, opcodes and result-slot codes for the SPI NOR program/erase sequencer.
// Used by every module in rtl/; depends on nothing else.
package spnor_pkg;

  localparam int PAGE_BYTES_DEF   = 256;
  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int ADDRESS_BITS_DEF = 24;
  localparam int QUEUE_DEPTH_DEF  = 4;
  localparam int ADDR_W           = 24;
  localparam int LIMIT_W          = 24;
  localparam logic [LIMIT_W-1:0] POLL_LIMIT_RESET = 24'd1680000;

  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_PROG  = 8'h02;
  localparam logic [7:0] OP_ERASE = 8'h20;
  localparam logic [7:0] OP_RDSR  = 8'h05;

  localparam logic [1:0] CMD_PROGRAM = 2'd0;
  localparam logic [1:0] CMD_ERASE   = 2'd1;
  localparam logic [1:0] CMD_STATUS  = 2'd2;

  typedef enum logic [1:0] {
    ACT_SELECT   = 2'd0,
    ACT_SEND     = 2'd1,
    ACT_DESELECT = 2'd2,
    ACT_REPORT   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_TIMEOUT = 2'd1,
    RES_REJECT  = 2'd2,
    RES_ABORT   = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DATA  = 3'd1,
    PH_POLL  = 3'd2,
    PH_EPOLL = 3'd3,
    PH_DRAIN = 3'd4
  } phase_t;

  // Fixed order of the result slots that one job can expand into.
  localparam int NUM_SLOTS = 14;
  localparam int SLOT_W    = 4;
  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  localparam logic [SLOT_W-1:0] SLOT_WE_SEL    = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_WE_OP     = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_WE_DESEL  = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_HDR_SEL   = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_HDR_OP    = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_ADDR_HI   = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_ADDR_MID  = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_ADDR_LO   = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_DATA      = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_POLL_DES  = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_POLL_SEL  = 4'd10;
  localparam logic [SLOT_W-1:0] SLOT_POLL_OP   = 4'd11;
  localparam logic [SLOT_W-1:0] SLOT_DESEL     = 4'd12;
  localparam logic [SLOT_W-1:0] SLOT_REPORT    = 4'd13;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] address;
    logic [7:0]        data_byte;
    logic              in_last;
  } in_item_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] out_byte;
    outcome_t   outcome;
    logic       end_of_run;
  } out_item_t;

  // One classified item: which groups of results it needs and their payload.
  typedef struct packed {
    logic              we;
    logic              hdr;
    logic              data_en;
    logic              poll;
    logic              desel;
    logic              report;
    logic [7:0]        opcode;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data_byte;
    outcome_t          outcome;
  } job_t;

  function automatic slot_mask_t job_mask(job_t j);
    slot_mask_t m;
    m = '0;
    m[SLOT_WE_SEL]   = j.we;
    m[SLOT_WE_OP]    = j.we;
    m[SLOT_WE_DESEL] = j.we;
    m[SLOT_HDR_SEL]  = j.hdr;
    m[SLOT_HDR_OP]   = j.hdr;
    m[SLOT_ADDR_HI]  = j.hdr;
    m[SLOT_ADDR_MID] = j.hdr;
    m[SLOT_ADDR_LO]  = j.hdr;
    m[SLOT_DATA]     = j.data_en;
    m[SLOT_POLL_DES] = j.poll;
    m[SLOT_POLL_SEL] = j.poll;
    m[SLOT_POLL_OP]  = j.poll;
    m[SLOT_DESEL]    = j.desel;
    m[SLOT_REPORT]   = j.report;
    return m;
  endfunction

endpackage

// ----- rtl/spnor_front.sv -----
// Front end of the sequencer: takes input items, tracks the program/erase phase
// and pushes one job per item that has results. Depends on spnor_pkg.
module spnor_front #(
  parameter int PAGE_BYTES   = spnor_pkg::PAGE_BYTES_DEF,
  parameter int SECTOR_BYTES = spnor_pkg::SECTOR_BYTES_DEF,
  parameter int ADDRESS_BITS = spnor_pkg::ADDRESS_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  spnor_pkg::in_item_t             in_data,
  input  logic                            q_full,
  input  logic                            cfg_wr_en,
  input  logic [spnor_pkg::LIMIT_W-1:0]   cfg_wr_data,
  output logic                            push,
  output spnor_pkg::job_t                 push_job
);

  localparam int AW = ADDRESS_BITS;
  // Pages are a power of two in size, so the page offset is the low address bits.
  localparam int PW = $clog2(PAGE_BYTES);
  localparam logic [AW-1:0] SECTOR_C = AW'(SECTOR_BYTES);

  spnor_pkg::phase_t                phase_r, phase_nxt;
  logic [AW-1:0]                    next_address_r, next_address_nxt;
  logic                             chunk_open_r, chunk_open_nxt;
  logic                             done_pending_r, done_pending_nxt;
  logic [spnor_pkg::LIMIT_W-1:0]    polls_left_r, polls_left_nxt;
  logic [spnor_pkg::LIMIT_W-1:0]    poll_limit_r;

  logic                             accept;
  logic [AW-1:0]                    cur_addr;
  logic [AW-1:0]                    addr_inc;
  logic [AW-1:0]                    erase_addr;
  logic                             page_end;
  logic                             chunk_close;
  logic                             open_now;
  logic                             fin;
  logic                             reject;
  logic [spnor_pkg::LIMIT_W-1:0]    poll_init;

  assign accept     = in_valid && !q_full;
  assign cur_addr   = (phase_r == spnor_pkg::PH_IDLE) ? in_data.address[AW-1:0]
                                                      : next_address_r;
  assign addr_inc   = cur_addr + AW'(1);
  assign page_end   = (addr_inc[PW-1:0] == '0);
  assign chunk_close = in_data.in_last || page_end;
  assign open_now   = (phase_r == spnor_pkg::PH_IDLE) ? 1'b0 : chunk_open_r;
  assign erase_addr = in_data.address[AW-1:0] * SECTOR_C;
  assign poll_init  = (poll_limit_r == '0) ? spnor_pkg::LIMIT_W'(1) : poll_limit_r;
  assign fin        = (phase_r == spnor_pkg::PH_EPOLL) || done_pending_r;

  always_comb begin
    phase_nxt        = phase_r;
    next_address_nxt = next_address_r;
    chunk_open_nxt   = chunk_open_r;
    done_pending_nxt = done_pending_r;
    polls_left_nxt   = polls_left_r;
    push_job         = '0;
    push_job.outcome = spnor_pkg::RES_OK;
    reject           = 1'b0;

    case (phase_r)
      spnor_pkg::PH_IDLE, spnor_pkg::PH_DATA: begin
        if (in_data.command == spnor_pkg::CMD_PROGRAM) begin
          push_job.we        = !open_now;
          push_job.hdr       = !open_now;
          push_job.opcode    = spnor_pkg::OP_PROG;
          push_job.addr      = spnor_pkg::ADDR_W'(cur_addr);
          push_job.data_en   = 1'b1;
          push_job.data_byte = in_data.data_byte;
          push_job.poll      = chunk_close;
          next_address_nxt   = addr_inc;
          chunk_open_nxt     = !chunk_close;
          if (chunk_close) begin
            phase_nxt        = spnor_pkg::PH_POLL;
            done_pending_nxt = in_data.in_last;
            polls_left_nxt   = poll_init;
          end else begin
            phase_nxt        = spnor_pkg::PH_DATA;
            done_pending_nxt = (phase_r == spnor_pkg::PH_IDLE) ? 1'b0 : done_pending_r;
          end
        end else if (phase_r == spnor_pkg::PH_IDLE &&
                     in_data.command == spnor_pkg::CMD_ERASE) begin
          push_job.we     = 1'b1;
          push_job.hdr    = 1'b1;
          push_job.opcode = spnor_pkg::OP_ERASE;
          push_job.addr   = spnor_pkg::ADDR_W'(erase_addr);
          push_job.poll   = 1'b1;
          polls_left_nxt  = poll_init;
          phase_nxt       = spnor_pkg::PH_EPOLL;
        end else begin
          reject = 1'b1;
        end
      end
      spnor_pkg::PH_POLL, spnor_pkg::PH_EPOLL: begin
        if (in_data.command == spnor_pkg::CMD_STATUS) begin
          if (!in_data.data_byte[0]) begin
            push_job.desel = 1'b1;
            if (fin) begin
              push_job.report  = 1'b1;
              push_job.outcome = spnor_pkg::RES_OK;
              phase_nxt        = spnor_pkg::PH_IDLE;
              done_pending_nxt = 1'b0;
            end else begin
              phase_nxt = spnor_pkg::PH_DATA;
            end
          end else if (polls_left_r <= spnor_pkg::LIMIT_W'(1)) begin
            polls_left_nxt   = '0;
            push_job.desel   = 1'b1;
            push_job.report  = 1'b1;
            push_job.outcome = spnor_pkg::RES_TIMEOUT;
            if (fin) begin
              phase_nxt        = spnor_pkg::PH_IDLE;
              done_pending_nxt = 1'b0;
            end else begin
              phase_nxt = spnor_pkg::PH_DRAIN;
            end
          end else begin
            polls_left_nxt = polls_left_r - spnor_pkg::LIMIT_W'(1);
          end
        end else begin
          reject = 1'b1;
        end
      end
      spnor_pkg::PH_DRAIN: begin
        if (in_data.command == spnor_pkg::CMD_PROGRAM) begin
          if (in_data.in_last) begin
            push_job.report  = 1'b1;
            push_job.outcome = spnor_pkg::RES_ABORT;
            phase_nxt        = spnor_pkg::PH_IDLE;
            done_pending_nxt = 1'b0;
          end
        end else begin
          reject = 1'b1;
        end
      end
      default: begin
        reject = 1'b1;
      end
    endcase

    // A rejected item reports once and leaves the state as it was.
    if (reject) begin
      push_job         = '0;
      push_job.report  = 1'b1;
      push_job.outcome = spnor_pkg::RES_REJECT;
      phase_nxt        = phase_r;
      next_address_nxt = next_address_r;
      chunk_open_nxt   = chunk_open_r;
      done_pending_nxt = done_pending_r;
      polls_left_nxt   = polls_left_r;
    end
  end

  assign push = accept && (spnor_pkg::job_mask(push_job) != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= spnor_pkg::PH_IDLE;
      next_address_r <= '0;
      chunk_open_r   <= 1'b0;
      done_pending_r <= 1'b0;
      polls_left_r   <= '0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      next_address_r <= next_address_nxt;
      chunk_open_r   <= chunk_open_nxt;
      done_pending_r <= done_pending_nxt;
      polls_left_r   <= polls_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r <= spnor_pkg::POLL_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      poll_limit_r <= cfg_wr_data;
    end
  end

endmodule

// ----- rtl/spnor_queue.sv -----
// Small job queue between the front end and the result expander.
// Register based, first in first out. Depends on spnor_pkg.
module spnor_queue #(
  parameter int QUEUE_DEPTH = spnor_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  spnor_pkg::job_t  push_job,
  input  logic             pop,
  output spnor_pkg::job_t  head,
  output logic             not_empty,
  output logic             full
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  spnor_pkg::job_t  mem_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- rtl/spnor_back.sv -----
// Result expander: walks the slots of each job in order, one result per cycle while the
// output is not stalled, into the output register. Depends on spnor_pkg.
module spnor_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spnor_pkg::job_t       head,
  input  logic                  not_empty,
  output logic                  pop,
  input  logic                  out_stall,
  output logic                  out_valid,
  output spnor_pkg::out_item_t  out_data
);

  spnor_pkg::job_t        job_r, job_nxt;
  spnor_pkg::slot_mask_t  mask_r, mask_nxt;
  spnor_pkg::slot_mask_t  eff_mask;
  spnor_pkg::slot_mask_t  rem_mask;
  spnor_pkg::job_t        cur_job;
  logic [spnor_pkg::SLOT_W-1:0] slot;
  logic                   out_free;
  logic                   have_work;
  logic                   out_valid_r;
  spnor_pkg::out_item_t   out_data_r, item;

  assign out_free  = !out_valid_r || !out_stall;
  assign have_work = (mask_r != '0) || not_empty;
  assign pop       = out_free && (mask_r == '0) && not_empty;
  assign cur_job   = (mask_r != '0) ? job_r : head;
  assign eff_mask  = (mask_r != '0) ? mask_r : spnor_pkg::job_mask(head);

  // Lowest pending slot goes out first.
  always_comb begin
    slot = '0;
    for (int i = spnor_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (eff_mask[i]) begin
        slot = spnor_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    rem_mask       = eff_mask;
    rem_mask[slot] = 1'b0;
  end

  always_comb begin
    item            = '0;
    item.action     = spnor_pkg::ACT_SEND;
    item.outcome    = spnor_pkg::RES_OK;
    item.end_of_run = (rem_mask == '0);
    case (slot)
      spnor_pkg::SLOT_WE_SEL,
      spnor_pkg::SLOT_HDR_SEL,
      spnor_pkg::SLOT_POLL_SEL: item.action   = spnor_pkg::ACT_SELECT;
      spnor_pkg::SLOT_WE_DESEL,
      spnor_pkg::SLOT_POLL_DES,
      spnor_pkg::SLOT_DESEL:    item.action   = spnor_pkg::ACT_DESELECT;
      spnor_pkg::SLOT_WE_OP:    item.out_byte = spnor_pkg::OP_WREN;
      spnor_pkg::SLOT_HDR_OP:   item.out_byte = cur_job.opcode;
      spnor_pkg::SLOT_ADDR_HI:  item.out_byte = cur_job.addr[23:16];
      spnor_pkg::SLOT_ADDR_MID: item.out_byte = cur_job.addr[15:8];
      spnor_pkg::SLOT_ADDR_LO:  item.out_byte = cur_job.addr[7:0];
      spnor_pkg::SLOT_DATA:     item.out_byte = cur_job.data_byte;
      spnor_pkg::SLOT_POLL_OP:  item.out_byte = spnor_pkg::OP_RDSR;
      spnor_pkg::SLOT_REPORT: begin
        item.action  = spnor_pkg::ACT_REPORT;
        item.outcome = cur_job.outcome;
      end
      default: item.action = spnor_pkg::ACT_REPORT;
    endcase
  end

  always_comb begin
    mask_nxt = mask_r;
    job_nxt  = job_r;
    if (out_free && have_work) begin
      mask_nxt = rem_mask;
      job_nxt  = cur_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (out_free) begin
        out_valid_r <= have_work;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (out_free && have_work) begin
      out_data_r <= item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/spi_nor_program_erase_sequencer_unit.sv -----
// SPI NOR program/erase sequencer, top level: front end, job queue, result expander.
// Depends on spnor_pkg, spnor_front, spnor_queue and spnor_back.
// The first result of an accepted item passes through the job queue register and then
// the output register. Throughput: one result per cycle while out_stall is low, set by
// the expander; an item holds the expander until all of its results are out, and a data
// byte in mid-page has one result and a chunk start up to twelve. Input is taken every
// cycle while the job queue has room. Synchronous reset clears all control state and
// loads poll_limit with 1680000.
module spi_nor_program_erase_sequencer_unit #(
  parameter int PAGE_BYTES   = spnor_pkg::PAGE_BYTES_DEF,
  parameter int SECTOR_BYTES = spnor_pkg::SECTOR_BYTES_DEF,
  parameter int ADDRESS_BITS = spnor_pkg::ADDRESS_BITS_DEF,
  parameter int QUEUE_DEPTH  = spnor_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  spnor_pkg::in_item_t            in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output spnor_pkg::out_item_t           out_data,
  input  logic                           cfg_wr_en,
  input  logic [spnor_pkg::LIMIT_W-1:0]  cfg_wr_data
);

  // The front end classifies each transfer against the current phase and turns it
  // into at most one job; status bytes that only count down the poll budget and
  // dropped bytes of an aborted run produce no job at all.
  logic             push;
  spnor_pkg::job_t  push_job;
  logic             q_full;
  logic             q_not_empty;
  logic             pop;
  spnor_pkg::job_t  head;

  // The queue is the only back pressure on the input side, so a result waiting
  // in the output register never blocks the next transfer by itself.
  assign in_stall = q_full;

  spnor_front #(
    .PAGE_BYTES   (PAGE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .q_full      (q_full),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .push_job    (push_job)
  );

  spnor_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // The expander walks the job's slots in flash order: write enable, command
  // header with address, data byte, status poll start, deselect and report.
  spnor_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .not_empty (q_not_empty),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
